// ----- hw/rtl/bhr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bhr_pkg: button hold / release timer shared types
// Field widths, register indexes, queue item and configuration structs.
// ----------------------------------------------------------------------------
package bhr_pkg;

   localparam int PIN_COUNT  = 12;
   localparam int IDX_W      = 5;
   localparam int TIME_W     = 16;
   localparam int PER_W      = 8;
   localparam int JOY1_LAST  = 3;
   localparam int JOY2_BASE  = 5;
   localparam int JOY2_LAST  = 8;
   localparam int DIV_STEPS  = TIME_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIENTATION   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESSED_LEVEL = 2'd2;

   localparam logic ACT_TICK  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   localparam logic [TIME_W-1:0] RELEASE_LIMIT_RST = 16'd30;

   typedef struct packed {
      logic [1:0]        orientation;
      logic [TIME_W-1:0] release_limit;
      logic              pressed_level;
   } bhr_cfg_type;

   typedef struct packed {
      logic                 is_query;
      logic [PIN_COUNT-1:0] pins;
      logic                 idx_ok;
      logic [IDX_W-1:0]     lane;
      logic [TIME_W-1:0]    threshold;
      logic [PER_W-1:0]     period;
   } bhr_item_type;

endpackage
`default_nettype wire

// ----- hw/rtl/bhr_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bhr_front: request classification
// Tags ticks and queries, rotates joystick indices, flags bad indices.
// ----------------------------------------------------------------------------
module bhr_front import bhr_pkg::*; #(
   parameter int NUM_BUTTONS = 12
) (
   input  wire bhr_cfg_type          cfg,
   input  wire                       req_valid,
   input  wire                       req_action,
   input  wire [PIN_COUNT-1:0]       req_pin_levels,
   input  wire [IDX_W-1:0]           req_button_index,
   input  wire [TIME_W-1:0]          req_hold_threshold,
   input  wire [PER_W-1:0]           req_repeat_period,
   input  wire                       q_full,
   output logic                      req_stall,
   output logic                      q_push,
   output bhr_item_type              q_item
);

   localparam logic [IDX_W:0] NB = (IDX_W+1)'(NUM_BUTTONS);

   logic [IDX_W-1:0] lane;
   logic [IDX_W-1:0] joy2_off;
   logic [1:0]       rot1;
   logic [1:0]       rot2;

   assign joy2_off = req_button_index - IDX_W'(JOY2_BASE);
   assign rot1     = req_button_index[1:0] + 2'd1 - cfg.orientation;
   assign rot2     = joy2_off[1:0] + 2'd1 - cfg.orientation;

   always_comb begin
      lane = req_button_index;
      if (req_button_index <= IDX_W'(JOY1_LAST)) begin
         lane = {3'b000, rot1};
      end else if (req_button_index >= IDX_W'(JOY2_BASE) &&
                   req_button_index <= IDX_W'(JOY2_LAST)) begin
         lane = IDX_W'(JOY2_BASE) + {3'b000, rot2};
      end
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_item.is_query  = (req_action == ACT_QUERY);
      q_item.pins      = req_pin_levels;
      q_item.idx_ok    = ({1'b0, req_button_index} < NB);
      q_item.lane      = lane;
      q_item.threshold = req_hold_threshold;
      q_item.period    = req_repeat_period;
   end

endmodule
`default_nettype wire

// ----- hw/rtl/bhr_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bhr_queue: two-entry item queue
// Decouples request acceptance from lane update and query evaluation.
// ----------------------------------------------------------------------------
module bhr_queue import bhr_pkg::*; (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  wire bhr_item_type push_item,
   input  wire               pop,
   output logic              full,
   output logic              valid,
   output bhr_item_type      pop_item
);

   bhr_item_type mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign valid    = (count_ff != 2'd0);
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/bhr_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bhr_back: lane counters and query engine
// Updates all lane counters on a tick; answers a query with a serial
// remainder check for auto-repeat, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module bhr_back import bhr_pkg::*; #(
   parameter int NUM_BUTTONS = 12
) (
   input  wire                clock,
   input  wire                reset,
   input  wire bhr_cfg_type   cfg,
   input  wire                q_valid,
   input  wire bhr_item_type  q_item,
   output logic               q_pop,
   input  wire                rsp_stall,
   output logic               rsp_valid,
   output logic [TIME_W-1:0]  rsp_pressed_time,
   output logic [TIME_W-1:0]  rsp_released_time,
   output logic               rsp_hold_fire
);

   localparam int LANE_W = $clog2(NUM_BUTTONS);
   localparam int CNT_W  = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} state_type;

   logic [TIME_W-1:0] held_ff [NUM_BUTTONS];
   logic [TIME_W-1:0] rel_ff  [NUM_BUTTONS];
   logic              tick_en;
   state_type         state_ff, state_in;

   assign q_pop   = q_valid && (state_ff == ST_IDLE);
   assign tick_en = q_pop && !q_item.is_query;

   // lane counters
   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
      logic              level;
      logic [TIME_W-1:0] held_in;
      logic [TIME_W-1:0] rel_in;
      logic [TIME_W:0]   rel_inc;

      if (i < PIN_COUNT) begin : g_pin
         assign level = q_item.pins[i];
      end else begin : g_nopin
         assign level = 1'b0;
      end

      assign rel_inc = {1'b0, rel_ff[i]} + (TIME_W+1)'(1);

      always_comb begin
         held_in = held_ff[i];
         rel_in  = rel_ff[i];
         if (level == cfg.pressed_level) begin
            if (held_ff[i] != '1) begin
               held_in = held_ff[i] + TIME_W'(1);
            end
            rel_in = '0;
         end else begin
            if (held_ff[i] != '0) begin
               rel_in = TIME_W'(1);
            end else if (rel_ff[i] != '0) begin
               rel_in = (rel_inc > {1'b0, cfg.release_limit}) ? '0 : rel_inc[TIME_W-1:0];
            end
            held_in = '0;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            held_ff[i] <= '0;
            rel_ff[i]  <= '0;
         end else if (tick_en) begin
            held_ff[i] <= held_in;
            rel_ff[i]  <= rel_in;
         end
      end
   end

   // query engine
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PER_W-1:0]  rem_ff, rem_in;
   logic [TIME_W-1:0] diff_ff, diff_in;
   logic [PER_W-1:0]  per_ff, per_in;
   logic              ok_ff, ok_in;
   logic [TIME_W-1:0] held_q_ff, held_q_in;
   logic [TIME_W-1:0] rel_q_ff, rel_q_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0] rsp_held_ff, rsp_held_in;
   logic [TIME_W-1:0] rsp_rel_ff, rsp_rel_in;
   logic              rsp_fire_ff, rsp_fire_in;

   logic [TIME_W-1:0] sel_held;
   logic [TIME_W-1:0] sel_rel;
   logic [PER_W:0]    rem_sh;
   logic [PER_W:0]    rem_sub;

   assign sel_held = q_item.idx_ok ? held_ff[q_item.lane[LANE_W-1:0]] : '0;
   assign sel_rel  = q_item.idx_ok ? rel_ff[q_item.lane[LANE_W-1:0]]  : '0;
   assign rem_sh   = {rem_ff, diff_ff[TIME_W-1]};
   assign rem_sub  = rem_sh - {1'b0, per_ff};

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      diff_in      = diff_ff;
      per_in       = per_ff;
      ok_in        = ok_ff;
      held_q_in    = held_q_ff;
      rel_q_in     = rel_q_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_held_in  = rsp_held_ff;
      rsp_rel_in   = rsp_rel_ff;
      rsp_fire_in  = rsp_fire_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && q_item.is_query) begin
               held_q_in = sel_held;
               rel_q_in  = sel_rel;
               diff_in   = sel_held - q_item.threshold;
               per_in    = q_item.period;
               ok_in     = (q_item.period != '0) && (sel_held > q_item.threshold);
               rem_in    = '0;
               cnt_in    = '0;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = (rem_sh >= {1'b0, per_ff}) ? rem_sub[PER_W-1:0] : rem_sh[PER_W-1:0];
            diff_in = {diff_ff[TIME_W-2:0], 1'b0};
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_held_in  = held_q_ff;
               rsp_rel_in   = rel_q_ff;
               rsp_fire_in  = ok_ff && (rem_ff == '0);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_ff      <= rem_in;
      diff_ff     <= diff_in;
      per_ff      <= per_in;
      ok_ff       <= ok_in;
      held_q_ff   <= held_q_in;
      rel_q_ff    <= rel_q_in;
      rsp_held_ff <= rsp_held_in;
      rsp_rel_ff  <= rsp_rel_in;
      rsp_fire_ff <= rsp_fire_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pressed_time  = rsp_held_ff;
   assign rsp_released_time = rsp_rel_ff;
   assign rsp_hold_fire     = rsp_fire_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/button_hold_release_timer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// button_hold_release_timer: per-button hold / release timer
// Request beats are ticks (sample all pins) or queries (read one button).
// A tick updates every lane's held and release counters and gives no
// response. A query gives one response beat: held time, release time and
// an auto-repeat fire flag; joystick indices are rotated by orientation.
// Requests enter a two-entry queue; req_stall is high while it is full.
// A query goes from queue head to rsp_valid via ST_IDLE (read the lane),
// ST_DIV (bit-serial remainder of (held - threshold) by the repeat period)
// and ST_DONE (load the response register); nothing pops until it ends.
// Ticks pop one per cycle while no query is in flight.
// While rsp_stall is high the response holds; the next query still
// computes and waits for the response register to free.
// Reset (synchronous) clears all counters, the queue and the response,
// and loads orientation 0, release limit 30, pressed level 0.
// csr_ready is always high; write only while no query is in flight.
// ----------------------------------------------------------------------------
module button_hold_release_timer import bhr_pkg::*; #(
   parameter int NUM_BUTTONS = 12
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire                   req_action,
   input  wire [PIN_COUNT-1:0]   req_pin_levels,
   input  wire [IDX_W-1:0]       req_button_index,
   input  wire [TIME_W-1:0]      req_hold_threshold,
   input  wire [PER_W-1:0]       req_repeat_period,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic [TIME_W-1:0]     rsp_pressed_time,
   output logic [TIME_W-1:0]     rsp_released_time,
   output logic                  rsp_hold_fire,
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire [CSR_IDX_W-1:0]   csr_index,
   input  wire [CSR_DATA_W-1:0]  csr_wdata
);

   bhr_cfg_type  cfg_ff, cfg_in;
   bhr_item_type push_item;
   bhr_item_type head_item;
   logic         q_push;
   logic         q_pop;
   logic         q_full;
   logic         q_valid;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ORIENTATION:   cfg_in.orientation   = csr_wdata[1:0];
            CSR_RELEASE_LIMIT: cfg_in.release_limit = csr_wdata[TIME_W-1:0];
            CSR_PRESSED_LEVEL: cfg_in.pressed_level = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.orientation   <= 2'd0;
         cfg_ff.release_limit <= RELEASE_LIMIT_RST;
         cfg_ff.pressed_level <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bhr_front #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_front (
      .cfg                (cfg_ff),
      .req_valid          (req_valid),
      .req_action         (req_action),
      .req_pin_levels     (req_pin_levels),
      .req_button_index   (req_button_index),
      .req_hold_threshold (req_hold_threshold),
      .req_repeat_period  (req_repeat_period),
      .q_full             (q_full),
      .req_stall          (req_stall),
      .q_push             (q_push),
      .q_item             (push_item)
   );

   bhr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .full      (q_full),
      .valid     (q_valid),
      .pop_item  (head_item)
   );

   bhr_back #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_valid           (q_valid),
      .q_item            (head_item),
      .q_pop             (q_pop),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_pressed_time  (rsp_pressed_time),
      .rsp_released_time (rsp_released_time),
      .rsp_hold_fire     (rsp_hold_fire)
   );

endmodule
`default_nettype wire

// ----- hw/rtl/bhr_check.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bhr_check: port-level checks for the button timer
// Response channel hold rules and counter consistency seen on responses.
// ----------------------------------------------------------------------------
module bhr_check import bhr_pkg::*; (
   input wire                clock,
   input wire                reset,
   input wire                rsp_valid,
   input wire                rsp_stall,
   input wire [TIME_W-1:0]   rsp_pressed_time,
   input wire [TIME_W-1:0]   rsp_released_time,
   input wire                rsp_hold_fire
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_pressed_time) &&
         $stable(rsp_released_time) && $stable(rsp_hold_fire))
      else $error("stalled response beat changed");

   a_fire_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hold_fire |-> rsp_pressed_time != '0)
      else $error("repeat fired on a released button");

   a_held_xor_rel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pressed_time != '0 |-> rsp_released_time == '0)
      else $error("held button reports a release time");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind button_hold_release_timer bhr_check u_bhr_check (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_pressed_time  (rsp_pressed_time),
   .rsp_released_time (rsp_released_time),
   .rsp_hold_fire     (rsp_hold_fire)
);
`default_nettype wire
